>>> hw/rtl/sha1s_pkg.sv
// Shared constants and control types for the SHA-1 stream hasher.
`default_nettype none

package sha1s_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int BLOCK_BYTES  = 64;
    localparam int LEN_BYTES    = 8;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    // Commands from the stream controller to the compression core.
    typedef struct packed {
        logic       push;       // shift one byte into the block buffer
        logic [7:0] push_byte;
        logic       start;      // compress the 64 buffered bytes
        logic       reinit;     // restore initial chaining values
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
    } core_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/sha1s_core.sv
// SHA-1 compression core: block buffer / schedule shift line and one shared round unit.
`default_nettype none

module sha1s_core
    import sha1s_pkg::*;
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  core_ctrl_t                       ctrl,
    output core_stat_t                       stat,
    output logic [DIGEST_WORDS-1:0][31:0]    chain
);

    typedef enum logic [1:0] {P_IDLE, P_ROUND, P_ADD} phase_t;

    phase_t                          phase_reg;
    logic [6:0]                      round_reg;
    logic [DIGEST_WORDS-1:0][31:0]   chain_reg;
    logic [8*BLOCK_BYTES-1:0]        buf_reg;
    logic [31:0]                     a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [31:0] w0, w2, w8, w13, sched_mix, sched_new;
    logic [31:0] f_val, k_val, temp;

    // Word i of the schedule window sits at the top end: word 0 is the oldest.
    assign w0  = buf_reg[511:480];
    assign w2  = buf_reg[447:416];
    assign w8  = buf_reg[255:224];
    assign w13 = buf_reg[95:64];
    assign sched_mix = w13 ^ w8 ^ w2 ^ w0;
    assign sched_new = {sched_mix[30:0], sched_mix[31]};

    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
    end

    assign temp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            round_reg <= '0;
            chain_reg <= H_INIT;
        end
        else
        begin
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        round_reg <= '0;
                        phase_reg <= P_ROUND;
                    end
                    if (ctrl.reinit)
                        chain_reg <= H_INIT;
                end
                P_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'(ROUNDS - 1))
                        phase_reg <= P_ADD;
                end
                P_ADD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    phase_reg    <= P_IDLE;
                end
                default:
                    phase_reg <= P_IDLE;
            endcase
        end
    end

    // Working variables and buffer: no reset needed.
    always_ff @(posedge clk)
    begin
        if (phase_reg == P_IDLE)
        begin
            if (ctrl.start)
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
            else if (ctrl.push)
                buf_reg <= {buf_reg[8*BLOCK_BYTES-9:0], ctrl.push_byte};
        end
        else if (phase_reg == P_ROUND)
        begin
            a_reg   <= temp;
            b_reg   <= a_reg;
            c_reg   <= {b_reg[1:0], b_reg[31:2]};
            d_reg   <= c_reg;
            e_reg   <= d_reg;
            buf_reg <= {buf_reg[8*BLOCK_BYTES-33:0], sched_new};
        end
    end

    assign stat.busy = (phase_reg != P_IDLE);
    assign chain     = chain_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher top level: byte intake, padding sequencer and digest output.
// Every 64th byte starts a compression: the shared round unit runs 80 rounds, one
// per cycle, between the load of the working variables and the chain update.
// A closing beat pads one byte per cycle (pausing while a filled block compresses),
// compresses one or two blocks, then gives five digest beats. No beat is taken meanwhile.
// Reset (rst_n low, asynchronous) restores the initial chaining values and clears counts.
`default_nettype none

module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tuser,   // has_byte
    input  wire         s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // final_word
);

    typedef enum logic [2:0] {S_IDLE, S_GO, S_WAIT, S_PAD, S_LEN, S_OUT} state_t;

    state_t       state_reg, ret_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  total_reg;
    logic         marker_reg;
    logic [2:0]   len_cnt_reg;
    logic [2:0]   idx_reg;

    core_ctrl_t                     ctrl;
    core_stat_t                     stat;
    logic [DIGEST_WORDS-1:0][31:0]  chain;

    logic        in_acc, out_acc;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign bit_len = {total_reg, 3'b000};
    assign len_byte = bit_len[{3'd7 - len_cnt_reg, 3'b000} +: 8];

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.push      = in_acc && s_axis_tuser;
                ctrl.push_byte = s_axis_tdata;
            end
            S_GO:
                ctrl.start = 1'b1;
            S_PAD:
            begin
                ctrl.push      = 1'b1;
                ctrl.push_byte = marker_reg ? PAD_MARKER : 8'h00;
            end
            S_LEN:
            begin
                ctrl.push      = 1'b1;
                ctrl.push_byte = len_byte;
            end
            S_OUT:
                ctrl.reinit = out_acc && (idx_reg == 3'(DIGEST_WORDS - 1));
            default:
                ctrl = '0;
        endcase
    end

    sha1s_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .chain (chain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            fill_reg    <= '0;
            total_reg   <= '0;
            marker_reg  <= 1'b0;
            len_cnt_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        marker_reg <= 1'b1;
                        if (s_axis_tuser)
                        begin
                            fill_reg  <= fill_reg + 6'd1;
                            total_reg <= total_reg + 61'd1;
                        end
                        if (s_axis_tuser && fill_reg == 6'(BLOCK_BYTES - 1))
                        begin
                            state_reg <= S_GO;
                            ret_reg   <= s_axis_tlast ? S_PAD : S_IDLE;
                        end
                        else if (s_axis_tlast)
                            state_reg <= S_PAD;
                    end
                end
                S_GO:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!stat.busy)
                        state_reg <= ret_reg;
                end
                S_PAD:
                begin
                    marker_reg <= 1'b0;
                    fill_reg   <= fill_reg + 6'd1;
                    if (fill_reg == 6'(BLOCK_BYTES - 1))
                    begin
                        state_reg <= S_GO;
                        ret_reg   <= S_PAD;
                    end
                    else if (fill_reg == 6'(BLOCK_BYTES - LEN_BYTES - 1))
                    begin
                        state_reg   <= S_LEN;
                        len_cnt_reg <= '0;
                    end
                end
                S_LEN:
                begin
                    fill_reg    <= fill_reg + 6'd1;
                    len_cnt_reg <= len_cnt_reg + 3'd1;
                    if (len_cnt_reg == 3'(LEN_BYTES - 1))
                    begin
                        state_reg <= S_GO;
                        ret_reg   <= S_OUT;
                        idx_reg   <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'(DIGEST_WORDS - 1))
                        begin
                            state_reg <= S_IDLE;
                            total_reg <= '0;
                            fill_reg  <= '0;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = chain[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == 3'(DIGEST_WORDS - 1));

endmodule

`default_nettype wire

>>> tb/sha1_digest_checker.sv
// Stream monitor for the SHA-1 hasher: predicts digest beats and scores the output channel.
`timescale 1ns / 100ps

module sha1_digest_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tuser,   // has_byte
    input  wire         s_axis_tlast,   // last_byte
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [31:0] m_axis_tdata,   // digest_word
    input  wire  [2:0]  m_axis_tuser,   // word_index
    input  wire         m_axis_tlast,   // final_word
    output int          mismatches,
    output int          words_pending
);

    localparam logic [31:0] RC_0 = 32'h5a827999;
    localparam logic [31:0] RC_1 = 32'h6ed9eba1;
    localparam logic [31:0] RC_2 = 32'h8f1bbcdc;
    localparam logic [31:0] RC_3 = 32'hca62c1d6;
    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam int          LEN_FIELD = 56;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_beat_t;

    digest_beat_t digest_q[$];

    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    int          fill;
    logic [60:0] msg_bytes;
    int          fail_cnt = 0;
    int          pending_cnt = 0;

    assign mismatches    = fail_cnt;
    assign words_pending = pending_cnt;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 5; i++)
            chain[i] = IV[i];
        fill      = 0;
        msg_bytes = '0;
    endtask

    // 80 rounds over the buffered block, schedule kept as a rolling 16-word window
    task automatic fold_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r%16] = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RC_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RC_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RC_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RC_3;
            end
            t = rotl(a, 5) + f + e + k + w[r%16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic absorb_beat(input logic has, input logic [7:0] data, input logic fin);
        logic [63:0]  bit_len;
        digest_beat_t beat;
        if (has)
        begin
            blk[fill] = data;
            fill++;
            msg_bytes++;
            if (fill == 64)
            begin
                fold_block();
                fill = 0;
            end
        end
        if (fin)
        begin
            blk[fill] = PAD_BYTE;
            fill++;
            // no room left for the length field: pad out and fold an extra block
            if (fill > LEN_FIELD)
            begin
                while (fill < 64)
                begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                fold_block();
                fill = 0;
            end
            while (fill < LEN_FIELD)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++)
                blk[LEN_FIELD+i] = bit_len[63-8*i -: 8];
            fold_block();
            for (int i = 0; i < 5; i++)
            begin
                beat.word = chain[i];
                beat.idx  = 3'(i);
                beat.fin  = (i == 4);
                digest_q.push_back(beat);
            end
            restart_message();
        end
    endtask

    initial
        restart_message();

    always @(posedge clk)
    begin : monitor
        digest_beat_t want;
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("unexpected digest beat: digest_word %h word_index %0d final_word %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_cnt++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (m_axis_tdata !== want.word)
                    begin
                        $error("digest_word: expected %h, got %h", want.word, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tuser !== want.idx)
                    begin
                        $error("word_index: expected %0d, got %0d", want.idx, m_axis_tuser);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want.fin)
                    begin
                        $error("final_word: expected %b, got %b", want.fin, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
        end
        pending_cnt = digest_q.size();
    end

endmodule

>>> tb/tb_sha1_stream_hasher.sv
// Top-level testbench for sha1_stream_hasher: byte stream stimulus, backpressure and verdict.
`timescale 1ns / 100ps

module tb_sha1_stream_hasher;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // data_byte
    logic        s_axis_tuser = 1'b0;   // has_byte
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // digest_word
    logic [2:0]  m_axis_tuser;          // word_index
    logic        m_axis_tlast;          // final_word

    int mismatches;
    int words_pending;
    int tx_idle_pct = 12;
    int rx_idle_pct = 49;
    int beats_sent = 0;
    int msgs_done = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha1_stream_hasher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha1_digest_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic has, input logic [7:0] data, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Hold the input off until every digest beat owed has come out.
    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
    endtask

    function automatic int pick_length();
        int boundary [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return $urandom_range(0, 12);
        else if (roll < 17)
            return boundary[$urandom_range(0, 7)];
        else
            return $urandom_range(0, 140);
    endfunction

    task automatic send_message(input int len);
        bit end_beat;
        end_beat = (len == 0) || ($urandom_range(0, 1) == 1);
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(1'b0, 8'($urandom), 1'b0);
                beats_sent++;
            end
            send_beat(1'b1, 8'($urandom), !end_beat && (n == len - 1));
            beats_sent++;
        end
        if (end_beat)
        begin
            send_beat(1'b0, 8'($urandom), 1'b1);
            beats_sent++;
        end
        msgs_done++;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle beat, empty message, short messages, byte extremes
        send_beat(1'b0, 8'hff, 1'b0);
        send_beat(1'b0, 8'h00, 1'b1);
        send_beat(1'b1, 8'h61, 1'b0);
        send_beat(1'b1, 8'h62, 1'b0);
        send_beat(1'b1, 8'h63, 1'b1);
        send_beat(1'b1, 8'h00, 1'b0);
        send_beat(1'b0, 8'ha5, 1'b0);
        send_beat(1'b1, 8'hff, 1'b0);
        send_beat(1'b0, 8'hff, 1'b1);
        send_beat(1'b1, 8'hff, 1'b1);
        send_beat(1'b0, 8'h00, 1'b1);
        send_beat(1'b0, 8'h5a, 1'b1);
        drain_digests();

        beats_sent = 0;
        while (beats_sent < 420 || msgs_done < 12)
        begin
            if (beats_sent >= 140 && tx_idle_pct == 12)
            begin
                drain_digests();
                tx_idle_pct = 49;
                rx_idle_pct = 12;
            end
            else if (beats_sent >= 280 && tx_idle_pct == 49)
            begin
                drain_digests();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_message(pick_length());
        end

        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
        // room for a stray beat from a closing pass
        repeat (300) @(negedge clk);

        if (mismatches == 0 && words_pending == 0)
            $display("tb_sha1_stream_hasher OK");
        else
            $display("tb_sha1_stream_hasher NOT OK");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("tb_sha1_stream_hasher NOT OK");
        $finish;
    end

endmodule
